>>> hdl/shs_pkg.sv
// Shared types, constants and SHA-256 bit functions for the stream hasher.
package shs_pkg;

    typedef logic [31:0] t_word;

    // Working variables a..h, with a at index 0.
    typedef logic [7:0][31:0] t_words;

    // Input kinds carried on the slave tuser bit.
    localparam logic KindData   = 1'b0;
    localparam logic KindFinish = 1'b1;

    // Padding and sequencing marks.
    localparam logic [7:0] PadMark   = 8'h80;
    localparam logic [5:0] LenStart  = 6'd56;
    localparam logic [5:0] LastByte  = 6'd63;
    localparam logic [5:0] LastRound = 6'd63;
    localparam logic [2:0] LastWord  = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    localparam t_word InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Round function sigma on the a word.
    function automatic t_word big_sigma0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    // Round function sigma on the e word.
    function automatic t_word big_sigma1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    // Message schedule sigma on the word fifteen back.
    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    // Message schedule sigma on the word two back.
    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

>>> hdl/shs_round.sv
// One SHA-256 compression round, shared by all 64 rounds of every block.
module shs_round (
    input  shs_pkg::t_words i_v,
    input  shs_pkg::t_word  i_k,
    input  shs_pkg::t_word  i_w,
    output shs_pkg::t_words o_v
);

    shs_pkg::t_word t1;
    shs_pkg::t_word t2;
    shs_pkg::t_word ch;
    shs_pkg::t_word maj;

    // Choice and majority over the working words.
    assign ch  = (i_v[4] & i_v[5]) ^ (~i_v[4] & i_v[6]);
    assign maj = (i_v[0] & i_v[1]) ^ (i_v[0] & i_v[2]) ^ (i_v[1] & i_v[2]);

    // The two temporaries of the round.
    assign t1 = i_v[7] + shs_pkg::big_sigma1(i_v[4]) + ch + i_k + i_w;
    assign t2 = shs_pkg::big_sigma0(i_v[0]) + maj;

    // Rotate the working words, folding in the new a and e.
    assign o_v[0] = t1 + t2;
    assign o_v[1] = i_v[0];
    assign o_v[2] = i_v[1];
    assign o_v[3] = i_v[2];
    assign o_v[4] = i_v[3] + t1;
    assign o_v[5] = i_v[4];
    assign o_v[6] = i_v[5];
    assign o_v[7] = i_v[6];

endmodule

>>> hdl/sha256_stream_hasher.sv
// SHA-256 hasher over a byte stream, with one round unit under a small sequencer.
//
//  channel  | dir | tdata                 | tuser            | tlast
//  ---------+-----+-----------------------+------------------+-----------
//  slave s  | in  | [7:0] data_byte       | [0] kind         | -
//  master m | out | [31:0] digest_word    | [2:0] word_index | last word
//
// A data byte is taken while idle. The byte that fills a block starts the 64
// rounds through the one round unit and then the chaining add.
// A finish shifts in one padding byte per cycle up to the block end (a second
// block when more than 55 bytes were pending), each block then compressed,
// and then gives eight digest words, one per cycle while the sink takes them.
// Reset loads the initial hash values and clears the byte and block counts.
// The slave side is ready only while idle; a stalled digest word holds.
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // [7:0] data_byte
    input  logic        i_s_tuser,  // [0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // [31:0] digest_word
    output logic [2:0]  o_m_tuser,  // [2:0] word_index
    output logic        o_m_tlast
);

    shs_pkg::t_state r_state;
    shs_pkg::t_state n_state;

    // Block store, also the 16-word schedule window; oldest word in the top bits.
    logic [511:0]    r_blk;
    logic [5:0]      r_fill;
    logic [54:0]     r_blocks;
    logic [63:0]     r_len;
    logic            r_len_ok;
    logic            r_pad_first;
    logic            r_pad_mode;
    logic            r_final;
    logic [5:0]      r_round;
    logic [2:0]      r_oidx;
    shs_pkg::t_words r_h;
    shs_pkg::t_words r_v;

    logic            s_acc;
    logic            m_acc;
    logic            pad_len;
    logic [7:0]      pad_byte;
    logic            byte_en;
    logic [7:0]      byte_val;
    shs_pkg::t_word  w_t;
    shs_pkg::t_word  w_next;
    shs_pkg::t_words round_v;

    assign s_acc = i_s_tvalid && o_s_tready;
    assign m_acc = o_m_tvalid && i_m_tready;

    // Padding byte: marker first, then zeros, then the length once allowed.
    assign pad_len  = r_len_ok && (r_fill >= shs_pkg::LenStart) && !r_pad_first;
    assign pad_byte = r_pad_first ? shs_pkg::PadMark : (pad_len ? r_len[63:56] : 8'h00);

    // Schedule window taps and the next schedule word.
    assign w_t    = r_blk[511 -: 32];
    assign w_next = shs_pkg::small_sigma1(r_blk[511 - 32 * 14 -: 32]) +
                    r_blk[511 - 32 * 9 -: 32] +
                    shs_pkg::small_sigma0(r_blk[511 - 32 * 1 -: 32]) + w_t;

    shs_round u_round (
        .i_v (r_v),
        .i_k (shs_pkg::RoundK[r_round]),
        .i_w (w_t),
        .o_v (round_v)
    );

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and byte shift control.
    always_comb begin
        n_state  = r_state;
        byte_en  = 1'b0;
        byte_val = i_s_tdata;
        case (r_state)
            shs_pkg::S_IDLE: begin
                if (s_acc) begin
                    if (i_s_tuser == shs_pkg::KindData) begin
                        byte_en = 1'b1;
                        if (r_fill == shs_pkg::LastByte) begin
                            n_state = shs_pkg::S_ROUND;
                        end
                    end else begin
                        n_state = shs_pkg::S_PAD;
                    end
                end
            end
            shs_pkg::S_PAD: begin
                byte_en  = 1'b1;
                byte_val = pad_byte;
                if (r_fill == shs_pkg::LastByte) begin
                    n_state = shs_pkg::S_ROUND;
                end
            end
            shs_pkg::S_ROUND: begin
                if (r_round == shs_pkg::LastRound) begin
                    n_state = shs_pkg::S_ADD;
                end
            end
            shs_pkg::S_ADD: begin
                if (r_final) begin
                    n_state = shs_pkg::S_OUT;
                end else if (r_pad_mode) begin
                    n_state = shs_pkg::S_PAD;
                end else begin
                    n_state = shs_pkg::S_IDLE;
                end
            end
            shs_pkg::S_OUT: begin
                if (m_acc && (r_oidx == shs_pkg::LastWord)) begin
                    n_state = shs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = shs_pkg::S_IDLE;
            end
        endcase
    end

    // Block store, working words and length shifter.
    always_ff @(posedge i_clk) begin
        if (byte_en) begin
            r_blk <= {r_blk[503:0], byte_val};
        end else if (r_state == shs_pkg::S_ROUND) begin
            r_blk <= {r_blk[479:0], w_next};
        end

        if (byte_en && (r_fill == shs_pkg::LastByte)) begin
            r_v <= r_h;
        end else if (r_state == shs_pkg::S_ROUND) begin
            r_v <= round_v;
        end

        if (s_acc && (i_s_tuser == shs_pkg::KindFinish)) begin
            r_len <= {r_blocks, r_fill, 3'b000};
        end else if ((r_state == shs_pkg::S_PAD) && pad_len) begin
            r_len <= {r_len[55:0], 8'h00};
        end
    end

    // Counters, padding flags and chaining state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_blocks    <= '0;
            r_len_ok    <= 1'b0;
            r_pad_first <= 1'b0;
            r_pad_mode  <= 1'b0;
            r_final     <= 1'b0;
            r_round     <= '0;
            r_oidx      <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= shs_pkg::InitH[i];
            end
        end else begin
            if (byte_en) begin
                r_fill <= r_fill + 6'd1;
            end

            // A finish starts the padding run.
            if (s_acc && (i_s_tuser == shs_pkg::KindFinish)) begin
                r_len_ok    <= (r_fill < shs_pkg::LenStart);
                r_pad_first <= 1'b1;
                r_pad_mode  <= 1'b1;
            end

            // The byte that ends a padded block decides if it is the last one.
            if (r_state == shs_pkg::S_PAD) begin
                r_pad_first <= 1'b0;
                if (r_fill == shs_pkg::LastByte) begin
                    if (pad_len) begin
                        r_final <= 1'b1;
                    end else begin
                        r_len_ok <= 1'b1;
                    end
                end
            end

            if (r_state == shs_pkg::S_ROUND) begin
                r_round <= r_round + 6'd1;
            end

            // Fold the working words into the chaining state.
            if (r_state == shs_pkg::S_ADD) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
                if (!r_pad_mode) begin
                    r_blocks <= r_blocks + 55'd1;
                end
            end

            // Shift the digest out word 0 first, refilling with the initial values.
            if ((r_state == shs_pkg::S_OUT) && m_acc) begin
                for (int i = 0; i < 7; i++) begin
                    r_h[i] <= r_h[i + 1];
                end
                r_h[7] <= shs_pkg::InitH[r_oidx];
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == shs_pkg::LastWord) begin
                    r_blocks   <= '0;
                    r_pad_mode <= 1'b0;
                    r_final    <= 1'b0;
                end
            end
        end
    end

    // Port outputs.
    assign o_s_tready = (r_state == shs_pkg::S_IDLE);
    assign o_m_tvalid = (r_state == shs_pkg::S_OUT);
    assign o_m_tdata  = r_h[0];
    assign o_m_tuser  = r_oidx;
    assign o_m_tlast  = (r_oidx == shs_pkg::LastWord);

    // Rounds advance one per cycle.
    a_round_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == shs_pkg::S_ROUND) && (r_round != shs_pkg::LastRound)
        |=> r_round == ($past(r_round) + 6'd1))
        else $error("round counter skipped");

    // A block is compressed only once all 64 bytes are in.
    a_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == shs_pkg::S_ADD) |-> (r_fill == 6'd0))
        else $error("compressed a partial block");

    // No bytes are pending while the digest goes out.
    a_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_fill == 6'd0) && r_final)
        else $error("digest out with bytes pending");

    // After the last word the hasher is idle and back at the start state.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_acc && o_m_tlast |=> o_s_tready && (r_blocks == 55'd0) &&
        (r_h[0] == shs_pkg::InitH[0]))
        else $error("hasher not restarted after digest");

endmodule
